/* rtl/core/isbn10_check_to_isbn13_top_assert.svh */
// Assertion macros for the checker of the ISBN-10 to ISBN-13 block.
`ifndef ISBN10_CHECK_TO_ISBN13_TOP_ASSERT_SVH
`define ISBN10_CHECK_TO_ISBN13_TOP_ASSERT_SVH

// Implication in the same cycle, switched off while reset is asserted.
`define ISBN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Implication on the following edge, also checked during reset.
`define ISBN_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

/* rtl/core/isbn_pkg.sv */
package isbn_pkg;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_X      = 8'h58;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

    localparam logic [3:0] X_VALUE     = 4'd10;
    localparam logic [3:0] LAST_WEIGHTED_IDX = 4'd9;
    localparam logic [3:0] ISBN_DIGITS = 4'd10;
    localparam logic [3:0] DIGIT_SAT   = 4'd11;
    localparam logic [2:0] HYPHEN_MAX  = 3'd3;
    localparam logic [2:0] HYPHEN_SAT  = 3'd4;
    localparam logic [3:0] SUM13_INIT  = 4'd8;
    localparam logic [4:0] MOD11       = 5'd11;

    typedef struct packed {
        logic       ok;
        logic [3:0] cd;
    } res_t;

    // Both operands are already reduced mod 11, so one subtraction suffices.
    function automatic logic [3:0] mod11_add(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MOD11) begin
            s = s - MOD11;
        end
        return s[3:0];
    endfunction

    // Reduces a value below 40 mod 10.
    function automatic logic [3:0] mod10_fold(input logic [5:0] v);
        logic [5:0] r;
        if (v >= 6'd30) begin
            r = v - 6'd30;
        end else if (v >= 6'd20) begin
            r = v - 6'd20;
        end else if (v >= 6'd10) begin
            r = v - 6'd10;
        end else begin
            r = v;
        end
        return r[3:0];
    endfunction

endpackage

/* rtl/core/isbn_acc.sv */
module isbn_acc (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic [7:0]       char_code,
    input  logic             is_last,
    output isbn_pkg::res_t   res
);

    logic [3:0] digit_count_reg, digit_count_next, upd_digit_count;
    logic [2:0] hyphen_count_reg, hyphen_count_next, upd_hyphen_count;
    logic       at_start_reg, at_start_next;
    logic       prev_hyphen_reg, prev_hyphen_next;
    logic       error_reg, error_next, upd_error;
    logic [3:0] dsum_reg, dsum_next, upd_dsum;
    logic [3:0] wsum_reg, wsum_next, upd_wsum;
    logic [3:0] sum13_reg, sum13_next, upd_sum13;

    logic       is_digit;
    logic       is_hyphen;
    logic       take;
    logic [3:0] val;
    logic [5:0] term13;

    always_comb begin
        is_digit  = (char_code >= isbn_pkg::CHAR_ZERO) && (char_code <= isbn_pkg::CHAR_NINE);
        is_hyphen = (char_code == isbn_pkg::CHAR_HYPHEN);
        // 'X' counts as the digit ten only when it closes the string.
        take      = is_digit || ((char_code == isbn_pkg::CHAR_X) && is_last);
        val       = is_digit ? char_code[3:0] : isbn_pkg::X_VALUE;
        // Even digit positions carry weight three in the ISBN-13 sum.
        term13    = digit_count_reg[0] ? {2'b00, val} : ({1'b0, val, 1'b0} + {2'b00, val});

        upd_digit_count  = digit_count_reg;
        upd_hyphen_count = hyphen_count_reg;
        upd_error        = error_reg;
        upd_dsum         = dsum_reg;
        upd_wsum         = wsum_reg;
        upd_sum13        = sum13_reg;

        if (take) begin
            if (digit_count_reg < isbn_pkg::ISBN_DIGITS) begin
                upd_dsum = isbn_pkg::mod11_add(dsum_reg, val);
                upd_wsum = isbn_pkg::mod11_add(wsum_reg, upd_dsum);
                if (digit_count_reg < isbn_pkg::LAST_WEIGHTED_IDX) begin
                    upd_sum13 = isbn_pkg::mod10_fold({2'b00, sum13_reg} + term13);
                end
            end
            if (digit_count_reg < isbn_pkg::DIGIT_SAT) begin
                upd_digit_count = digit_count_reg + 4'd1;
            end
        end else if (is_hyphen) begin
            if (at_start_reg || prev_hyphen_reg || is_last) begin
                upd_error = 1'b1;
            end
            if (hyphen_count_reg < isbn_pkg::HYPHEN_SAT) begin
                upd_hyphen_count = hyphen_count_reg + 3'd1;
            end
        end else begin
            upd_error = 1'b1;
        end

        res.ok = !upd_error && (upd_digit_count == isbn_pkg::ISBN_DIGITS)
                 && (upd_hyphen_count <= isbn_pkg::HYPHEN_MAX)
                 && ((upd_hyphen_count != isbn_pkg::HYPHEN_MAX) || prev_hyphen_reg)
                 && (upd_wsum == 4'd0);
        if (!res.ok || (upd_sum13 == 4'd0)) begin
            res.cd = 4'd0;
        end else begin
            res.cd = isbn_pkg::X_VALUE - upd_sum13;
        end

        digit_count_next  = digit_count_reg;
        hyphen_count_next = hyphen_count_reg;
        at_start_next     = at_start_reg;
        prev_hyphen_next  = prev_hyphen_reg;
        error_next        = error_reg;
        dsum_next         = dsum_reg;
        wsum_next         = wsum_reg;
        sum13_next        = sum13_reg;
        if (step_en) begin
            if (is_last) begin
                // The string is finished, so start fresh for the next one.
                digit_count_next  = 4'd0;
                hyphen_count_next = 3'd0;
                at_start_next     = 1'b1;
                prev_hyphen_next  = 1'b0;
                error_next        = 1'b0;
                dsum_next         = 4'd0;
                wsum_next         = 4'd0;
                sum13_next        = isbn_pkg::SUM13_INIT;
            end else begin
                digit_count_next  = upd_digit_count;
                hyphen_count_next = upd_hyphen_count;
                at_start_next     = 1'b0;
                prev_hyphen_next  = is_hyphen;
                error_next        = upd_error;
                dsum_next         = upd_dsum;
                wsum_next         = upd_wsum;
                sum13_next        = upd_sum13;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg  <= 4'd0;
            hyphen_count_reg <= 3'd0;
            at_start_reg     <= 1'b1;
            prev_hyphen_reg  <= 1'b0;
            error_reg        <= 1'b0;
            dsum_reg         <= 4'd0;
            wsum_reg         <= 4'd0;
            sum13_reg        <= isbn_pkg::SUM13_INIT;
        end else begin
            digit_count_reg  <= digit_count_next;
            hyphen_count_reg <= hyphen_count_next;
            at_start_reg     <= at_start_next;
            prev_hyphen_reg  <= prev_hyphen_next;
            error_reg        <= error_next;
            dsum_reg         <= dsum_next;
            wsum_reg         <= wsum_next;
            sum13_reg        <= sum13_next;
        end
    end

endmodule

/* rtl/core/isbn10_check_to_isbn13_top.sv */
// ISBN-10 checker with ISBN-13 check digit for the 978 prefix.
// The input channel (s_valid, s_ready, s_char_code, s_is_last) carries one
// ASCII character of a hyphenated ISBN-10 per transfer; s_is_last marks the
// final character of a string. Only the final character produces a result
// transfer on the output channel (m_valid, m_ready, m_valid_res,
// m_check_digit13); m_check_digit13 is zero when the string is invalid.
// One character is taken per cycle while no final character waits on a
// stalled result. The running counts and sums are updated from the input
// register, and the result of a final character is registered in the
// output register, from which it is offered on the output channel.
// After reset both registers are empty and the running state stands at the
// start of a new string; each string's final character returns it there.
// While the receiver stalls, the pending result holds in the output
// register; further characters that are not final keep flowing, and a
// final character waits in the input register until the result is taken.
module isbn10_check_to_isbn13_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_valid_res,
    output logic [3:0] m_check_digit13
);

    logic           in_valid_reg, in_valid_next;
    logic [7:0]     in_char_reg;
    logic           in_last_reg;
    logic           out_valid_reg, out_valid_next;
    isbn_pkg::res_t out_res_reg;
    isbn_pkg::res_t res;
    logic           advance;

    // A character that is not final needs no room in the output register.
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    isbn_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .char_code (in_char_reg),
        .is_last   (in_last_reg),
        .res       (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_is_last;
        end
        if (advance && in_last_reg) begin
            out_res_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_valid_res     = out_res_reg.ok;
    assign m_check_digit13 = out_res_reg.cd;

endmodule

/* rtl/core/isbn_chk.sv */
`include "isbn10_check_to_isbn13_top_assert.svh"

module isbn_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_char_code,
    input logic       s_is_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_valid_res,
    input logic [3:0] m_check_digit13
);

    // A character offered on the input stays put until it is taken.
    `ISBN_ASSERT_NXT(a_in_hold, aclk, aresetn && s_valid && !s_ready,
                     s_valid && $stable(s_char_code) && $stable(s_is_last))

    // A stalled result must stay put until the receiver takes it.
    `ISBN_ASSERT_NXT(a_out_hold, aclk, aresetn && m_valid && !m_ready,
                     m_valid && $stable(m_valid_res) && $stable(m_check_digit13))

    // Reset empties the output register.
    `ISBN_ASSERT_NXT(a_reset_empty, aclk, !aresetn, !m_valid)

    // An invalid string never reports a check digit.
    `ISBN_ASSERT_IMP(a_invalid_zero, aclk, aresetn, m_valid && !m_valid_res,
                     m_check_digit13 == 4'd0)

    // The check digit is a decimal digit.
    `ISBN_ASSERT_IMP(a_digit_range, aclk, aresetn, m_valid, m_check_digit13 <= 4'd9)

endmodule

bind isbn10_check_to_isbn13_top isbn_chk u_isbn_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_char_code     (s_char_code),
    .s_is_last       (s_is_last),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_valid_res     (m_valid_res),
    .m_check_digit13 (m_check_digit13)
);
